>>> sv/prat_pkg.sv
// ----------------------------------------------------------------------------
// prat_pkg
// Shared types and constants for the rotor angle tracking PLL.
// ----------------------------------------------------------------------------
package prat_pkg;

  localparam logic [1:0] KIND_PREDICT = 2'd0;
  localparam logic [1:0] KIND_CORRECT = 2'd1;
  localparam logic [1:0] KIND_LOAD    = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_MAXINV = 3'd2;
  localparam logic [2:0] REG_MININT = 3'd3;
  localparam logic [2:0] REG_MAXINT = 3'd4;

  localparam logic [31:0] LOCK_COUNT = 32'd3;

  // multiplier operand select
  typedef enum logic [1:0] {
    MOP_VEL_AGE = 2'd0,
    MOP_VEL_EL  = 2'd1,
    MOP_KI_DT   = 2'd2,
    MOP_KP_DT   = 2'd3
  } mop_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch input item
    logic load_angle;  // load angle state
    logic mul_start;   // start serial multiply
    mop_t mul_op;
    logic gain_mul;    // gain*dt product (second operand mag)
    logic apply_pred;  // position += product
    logic set_atmeas;  // at_meas = position - product; compute innovation
    logic apply_vel;   // velocity += product
    logic apply_pos;   // at_meas += product
    logic final_pos;   // position = at_meas + product; commit sample
    logic clear_first;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ready_trk;
    logic       first_pend;
    logic       mul_done;
    logic       outlier;
  } dp_stat_t;

endpackage

>>> sv/pll_rotor_angle_tracker.sv
// ----------------------------------------------------------------------------
// pll_rotor_angle_tracker
// Second-order PLL tracking rotor angle from timestamped encoder samples.
// ----------------------------------------------------------------------------
// Load and idle items go straight to the result; predict uses one multiply,
//   outlier correction one, full correction four.
// Throughput: one item at a time, next input in the cycle after the result transfer;
//   limited by the serial 64x64 multiplier, used up to four times in sequence.
// Reset: rst synchronous active high; clears estimator state, registers take
//   their reset values, tracker not initialized.
module pll_rotor_angle_tracker #(
  parameter int ANGLE_BITS    = 24,
  parameter int VEL_FRAC_BITS = 56
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  kind,
  input  logic [23:0] meas_angle,
  input  logic [31:0] meas_time,
  input  logic [31:0] now_time,
  input  logic [31:0] elapsed_cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] est_position,
  output logic signed [63:0] est_velocity,
  output logic signed [24:0] angle_error,
  output logic [31:0] meas_interval,
  output logic [31:0] sample_age,
  output logic [31:0] sample_count,
  output logic        locked,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  prat_pkg::dp_cmd_t  cmd;
  prat_pkg::dp_stat_t stat;

  logic [31:0] loop_kp, loop_ki;
  logic [23:0] max_innovation, max_interval;
  logic [20:0] min_interval;
  logic [63:0] pos_w, vel_w;
  logic [24:0] err_w;

  assign pready = 1'b1;

  // config register file, word addressed
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_kp <= 32'd22222; loop_ki <= 32'd3845; max_innovation <= 24'd1398101;
      min_interval <= 21'd170; max_interval <= 24'd1700000;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        prat_pkg::REG_KP:     loop_kp        <= pwdata;
        prat_pkg::REG_KI:     loop_ki        <= pwdata;
        prat_pkg::REG_MAXINV: max_innovation <= pwdata[23:0];
        prat_pkg::REG_MININT: min_interval   <= pwdata[20:0];
        prat_pkg::REG_MAXINT: max_interval   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      prat_pkg::REG_KP:     prdata = loop_kp;
      prat_pkg::REG_KI:     prdata = loop_ki;
      prat_pkg::REG_MAXINV: prdata = {8'd0, max_innovation};
      prat_pkg::REG_MININT: prdata = {11'd0, min_interval};
      prat_pkg::REG_MAXINT: prdata = {8'd0, max_interval};
      default:              prdata = '0;
    endcase
  end

  prat_ctrl u_ctrl (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  prat_datapath #(.ANGLE_BITS(ANGLE_BITS), .VEL_FRAC_BITS(VEL_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .kind(kind),
    .meas_angle(meas_angle), .meas_time(meas_time), .now_time(now_time),
    .elapsed_cycles(elapsed_cycles), .loop_kp(loop_kp), .loop_ki(loop_ki),
    .max_innovation(max_innovation), .min_interval(min_interval),
    .max_interval(max_interval), .est_position(pos_w), .est_velocity(vel_w),
    .angle_error(err_w), .meas_interval(meas_interval), .sample_age(sample_age),
    .sample_count(sample_count)
  );

  assign est_position = pos_w;
  assign est_velocity = vel_w;
  assign angle_error  = err_w;
  // lock once three samples are in
  assign locked       = (sample_count >= prat_pkg::LOCK_COUNT);
endmodule

>>> sv/prat_mul.sv
// ----------------------------------------------------------------------------
// prat_mul
// Serial 64x64 unsigned multiplier, 16 bits of b per cycle.
// ----------------------------------------------------------------------------
module prat_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   cnt;
  logic         busy;
  logic [79:0]  part;

  assign part = a_r * b_r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      b_r  <= b_r >> 16;
      prod <= {16'd0, prod[127:16]} + {part, 48'd0};
    end
  end
endmodule

>>> sv/prat_datapath.sv
// ----------------------------------------------------------------------------
// prat_datapath
// Estimator state, innovation logic and operand routing to the multiplier.
// ----------------------------------------------------------------------------
module prat_datapath #(
  parameter int ANGLE_BITS    = 24,
  parameter int VEL_FRAC_BITS = 56
) (
  input  logic               clk,
  input  logic               rst,
  input  prat_pkg::dp_cmd_t  cmd,
  output prat_pkg::dp_stat_t stat,
  input  logic [1:0]         kind,
  input  logic [23:0]        meas_angle,
  input  logic [31:0]        meas_time,
  input  logic [31:0]        now_time,
  input  logic [31:0]        elapsed_cycles,
  input  logic [31:0]        loop_kp,
  input  logic [31:0]        loop_ki,
  input  logic [23:0]        max_innovation,
  input  logic [20:0]        min_interval,
  input  logic [23:0]        max_interval,
  output logic [63:0]        est_position,
  output logic [63:0]        est_velocity,
  output logic [24:0]        angle_error,
  output logic [31:0]        meas_interval,
  output logic [31:0]        sample_age,
  output logic [31:0]        sample_count
);
  localparam int VSH = VEL_FRAC_BITS - 32;
  localparam int GSH = 80 - VEL_FRAC_BITS;
  localparam int ASH = 32 - ANGLE_BITS;

  logic [1:0]  kind_r;
  logic [23:0] angle_r;
  logic [31:0] mt_r, nt_r, el_r;
  logic [63:0] position, velocity, at_meas;
  logic [31:0] stamp, count, interval, age_r;
  logic [24:0] err_r;
  logic        trk, first_p;
  logic        neg, outl;
  logic [32:0] mag;
  logic [31:0] dt;
  logic        mneg;

  logic [63:0]  ma, mb;
  logic [127:0] prod;
  logic         mdone;
  logic [127:0] sprod;
  logic [63:0]  shifted;

  logic [31:0] age_w, raw_dt, dt_lo;
  logic [63:0] meas_q, diff_w, vmag;
  logic [31:0] frac_w;
  logic        neg_w;
  logic [32:0] mag_w;
  logic [63:0] err_w;

  function automatic logic [63:0] ang_q(input logic [23:0] a);
    logic [31:0] m;
    m = 32'(a) & ((ANGLE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ANGLE_BITS) - 32'd1));
    return {32'd0, m << ASH};
  endfunction

  assign age_w  = nt_r - mt_r;
  assign raw_dt = mt_r - stamp;
  assign dt_lo  = (raw_dt < 32'(min_interval)) ? 32'(min_interval) : raw_dt;
  assign vmag   = velocity[63] ? (64'd0 - velocity) : velocity;

  always_comb begin
    case (cmd.mul_op)
      prat_pkg::MOP_VEL_AGE: begin ma = vmag; mb = {32'd0, age_w}; end
      prat_pkg::MOP_VEL_EL:  begin ma = vmag; mb = {32'd0, el_r}; end
      prat_pkg::MOP_KI_DT:   begin ma = {32'd0, loop_ki} * {32'd0, dt}; mb = {31'd0, mag}; end
      prat_pkg::MOP_KP_DT:   begin ma = {32'd0, loop_kp} * {32'd0, dt}; mb = {31'd0, mag}; end
      default:               begin ma = '0; mb = '0; end
    endcase
  end

  prat_mul u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(ma), .b(mb),
    .prod(prod), .done(mdone)
  );

  // sign of the product follows the operand pair being started
  always_ff @(posedge clk) begin
    if (cmd.mul_start)
      mneg <= (cmd.mul_op == prat_pkg::MOP_KI_DT || cmd.mul_op == prat_pkg::MOP_KP_DT) ?
              neg : velocity[63];
  end

  assign sprod   = mneg ? (128'd0 - prod) : prod;
  assign shifted = cmd.gain_mul ?
                   ((cmd.mul_op == prat_pkg::MOP_KI_DT) ? 64'(sprod >> GSH) : 64'(sprod >> 32))
                   : 64'(sprod >> VSH);

  assign meas_q = ang_q(angle_r);
  assign diff_w = meas_q - (position - shifted);
  assign frac_w = diff_w[31:0];
  assign neg_w  = frac_w > 32'h8000_0000;
  assign mag_w  = neg_w ? (33'h1_0000_0000 - {1'b0, frac_w}) : {1'b0, frac_w};
  assign err_w  = 64'((neg_w ? (128'd0 - 128'(mag_w)) : 128'(mag_w)) >> ASH);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind;
      angle_r <= meas_angle;
      mt_r    <= meas_time;
      nt_r    <= now_time;
      el_r    <= elapsed_cycles;
    end
    if (cmd.set_atmeas) begin
      at_meas <= position - shifted;
      neg     <= neg_w;
      mag     <= mag_w;
      outl    <= mag_w > (33'(max_innovation) << ASH);
      dt      <= (dt_lo > 32'(max_interval)) ? 32'(max_interval) : dt_lo;
    end
    if (cmd.apply_pos) at_meas <= at_meas + shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0; velocity <= '0; stamp <= '0; count <= '0;
      interval <= '0; age_r <= '0; err_r <= '0; trk <= 1'b0; first_p <= 1'b0;
    end else begin
      if (cmd.load_angle) begin
        position <= ang_q(angle_r);
        velocity <= '0; stamp <= mt_r; count <= '0; err_r <= '0;
        interval <= '0; age_r <= '0; trk <= 1'b1; first_p <= 1'b1;
      end
      if (cmd.clear_first) first_p <= 1'b0;
      if (cmd.apply_pred) position <= position + shifted;
      if (cmd.set_atmeas) err_r <= err_w[24:0];
      if (cmd.apply_vel) velocity <= velocity + shifted;
      if (cmd.final_pos) begin
        position <= at_meas + shifted;
        interval <= raw_dt; age_r <= age_w; count <= count + 32'd1; stamp <= mt_r;
      end
    end
  end

  assign stat = '{kind: kind_r, ready_trk: trk, first_pend: first_p,
                  mul_done: mdone, outlier: outl};

  assign est_position  = position;
  assign est_velocity  = velocity;
  assign angle_error   = err_r;
  assign meas_interval = interval;
  assign sample_age    = age_r;
  assign sample_count  = count;
endmodule

>>> sv/prat_ctrl.sv
// ----------------------------------------------------------------------------
// prat_ctrl
// Sequencer: input transfer, multiply steps, result register handshake.
// ----------------------------------------------------------------------------
module prat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output prat_pkg::dp_cmd_t  cmd,
  input  prat_pkg::dp_stat_t stat
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_DEC  = 10'b0000000010, S_PRED = 10'b0000000100,
    S_BACK = 10'b0000001000, S_CHK  = 10'b0000010000, S_VEL  = 10'b0000100000,
    S_POS  = 10'b0001000000, S_FWDS = 10'b0010000000, S_FWD  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign ready     = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_op = prat_pkg::MOP_VEL_AGE;
    case (state)
      S_IDLE: if (valid) begin cmd.capture = 1'b1; state_next = S_DEC; end
      S_DEC: begin
        case (stat.kind)
          prat_pkg::KIND_PREDICT: begin
            if (stat.ready_trk) begin
              cmd.mul_start = 1'b1; cmd.mul_op = prat_pkg::MOP_VEL_EL; state_next = S_PRED;
            end else state_next = S_OUT;
          end
          prat_pkg::KIND_CORRECT: begin
            if (!stat.ready_trk || stat.first_pend) begin
              cmd.load_angle = 1'b1;
              state_next = S_OUT;
            end else begin
              cmd.mul_start = 1'b1; state_next = S_BACK;
            end
          end
          prat_pkg::KIND_LOAD: begin cmd.load_angle = 1'b1; state_next = S_OUT; end
          default: state_next = S_OUT;
        endcase
        // first sample after load: load again, then disarm
        if (stat.kind == prat_pkg::KIND_CORRECT && stat.ready_trk && stat.first_pend)
          cmd.clear_first = 1'b1;
      end
      S_PRED: begin
        cmd.mul_op = prat_pkg::MOP_VEL_EL;
        if (stat.mul_done) begin cmd.apply_pred = 1'b1; state_next = S_OUT; end
      end
      S_BACK: if (stat.mul_done) begin cmd.set_atmeas = 1'b1; state_next = S_CHK; end
      S_CHK: begin
        if (stat.outlier) state_next = S_OUT;
        else begin
          cmd.mul_start = 1'b1; cmd.gain_mul = 1'b1;
          cmd.mul_op = prat_pkg::MOP_KI_DT; state_next = S_VEL;
        end
      end
      S_VEL: begin
        cmd.gain_mul = 1'b1; cmd.mul_op = prat_pkg::MOP_KI_DT;
        if (stat.mul_done) begin cmd.apply_vel = 1'b1; state_next = S_POS; end
      end
      S_POS: begin
        cmd.gain_mul = 1'b1; cmd.mul_op = prat_pkg::MOP_KP_DT;
        cmd.mul_start = 1'b1; state_next = S_FWDS;
      end
      S_FWDS: begin
        cmd.gain_mul = 1'b1; cmd.mul_op = prat_pkg::MOP_KP_DT;
        if (stat.mul_done) begin
          // gain product lands while the forward projection starts
          cmd.apply_pos = 1'b1; state_next = S_FWD;
          cmd.mul_start = 1'b1;
          cmd.mul_op = prat_pkg::MOP_VEL_AGE;
        end
      end
      S_FWD: begin
        if (stat.mul_done) begin cmd.final_pos = 1'b1; state_next = S_OUT; end
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  ap_no_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cmd.mul_start) else $error("multiply started while idle");
  ap_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  ap_done_busy: assert property (@(posedge clk) disable iff (rst)
    stat.mul_done |-> !(state == S_IDLE || state == S_OUT)) else $error("stray done");
endmodule
